FILE: hw/rtl/dcdc_voltage_ramp_sequencer_assert.svh
// Assertion macros, clocked on clk, disabled in reset.
`ifndef DCDC_VOLTAGE_RAMP_SEQUENCER_ASSERT_SVH
`define DCDC_VOLTAGE_RAMP_SEQUENCER_ASSERT_SVH

// same-cycle implication
`define DVRS_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication
`define DVRS_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

FILE: hw/rtl/dvrs_pkg.sv
package dvrs_pkg;

  localparam logic [7:0]  ADDR_BASE   = 8'h20;
  localparam logic [2:0]  RAIL_COARSE = 3'd1;
  localparam logic [2:0]  RAIL_MID    = 3'd5;

  localparam logic [5:0]  MASK_NARROW = 6'h1f;
  localparam logic [5:0]  MASK_WIDE   = 6'h3f;

  localparam logic [12:0] BASE_COARSE = 13'd1600;
  localparam logic [6:0]  STEP_COARSE = 7'd100;
  localparam logic [12:0] BASE_MID    = 13'd1000;
  localparam logic [6:0]  STEP_MID    = 7'd50;
  localparam logic [12:0] BASE_FINE   = 13'd600;
  localparam logic [6:0]  STEP_FINE   = 7'd20;

  localparam int ALU_W = 14;

  typedef struct packed {
    logic [5:0]  mask;
    logic [12:0] base;
    logic [6:0]  step;
  } enc_t;

  typedef struct packed {
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
    logic [ALU_W-1:0] c;
  } alu_op_t;

  typedef struct packed {
    logic [ALU_W-1:0] sum;
    logic             lt;
    logic             eq;
  } alu_res_t;

  function automatic enc_t rail_enc(input logic [2:0] rail);
    enc_t e;
    if (rail == RAIL_COARSE) begin
      e = '{mask: MASK_NARROW, base: BASE_COARSE, step: STEP_COARSE};
    end else if (rail == RAIL_MID) begin
      e = '{mask: MASK_NARROW, base: BASE_MID, step: STEP_MID};
    end else begin
      e = '{mask: MASK_WIDE, base: BASE_FINE, step: STEP_FINE};
    end
    return e;
  endfunction

endpackage

FILE: hw/rtl/dvrs_alu.sv
module dvrs_alu
  import dvrs_pkg::*;
(
  input  alu_op_t  op,
  output alu_res_t res
);

  always_comb begin
    res.sum = op.a + op.b;
    res.lt  = op.a < op.c;
    res.eq  = op.a == op.c;
  end

endmodule

FILE: hw/rtl/dcdc_voltage_ramp_sequencer.sv
// Ramps one regulator rail to a target voltage by single index steps. A request
// (start while busy is low) is first registered in a setup step, then indices
// are tested in turn (up to 64, through the shared add/compare unit), then
// register writes are issued (up to 63), with a check step when no
// write is needed. Each write appears on reg_addr/reg_value for exactly one
// cycle with strobe high; the receiver cannot stall, so every write must be
// taken when shown. last_write marks the final write of a ramp.
`include "dcdc_voltage_ramp_sequencer_assert.svh"

module dcdc_voltage_ramp_sequencer
  import dvrs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  rail,
  input  logic [12:0] target_mv,
  input  logic [7:0]  present_reg,
  output logic        strobe,
  output logic [7:0]  reg_addr,
  output logic [7:0]  reg_value,
  output logic        last_write
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_INDEX = 2'd1;
  localparam logic [1:0] ST_RAMP  = 2'd2;

  logic [1:0]  state;
  logic [5:0]  mask;
  logic [12:0] volt;
  logic [6:0]  step;
  logic [12:0] tgt;
  logic [5:0]  idx;
  logic [5:0]  cur;
  logic [5:0]  to;
  logic [7:0]  upper;
  logic [7:0]  addr;
  enc_t        enc;
  alu_op_t     op;
  alu_res_t    res;
  logic [5:0]  cur_next;

  assign busy     = (state != ST_IDLE);
  assign enc      = rail_enc(rail);
  assign cur_next = res.sum[5:0];

  always_comb begin
    op.a = {1'b0, volt};
    op.b = {7'b0, step};
    op.c = {1'b0, tgt};
    if (state == ST_RAMP) begin
      op.a = {8'b0, cur};
      op.c = {8'b0, to};
      op.b = (cur < to) ? ALU_W'(1) : {ALU_W{1'b1}};
    end
  end

  dvrs_alu u_alu (
    .op  (op),
    .res (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      strobe     <= 1'b0;
      last_write <= 1'b0;
    end else begin
      strobe     <= 1'b0;
      last_write <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            mask  <= enc.mask;
            volt  <= enc.base;
            step  <= enc.step;
            tgt   <= target_mv;
            idx   <= '0;
            cur   <= present_reg[5:0] & enc.mask;
            upper <= present_reg & ~{2'b00, enc.mask};
            addr  <= ADDR_BASE + {5'b0, rail};
            state <= ST_INDEX;
          end
        end
        ST_INDEX: begin
          if (idx != mask && res.lt) begin
            volt <= res.sum[12:0];
            idx  <= idx + 6'd1;
          end else begin
            to    <= idx;
            state <= ST_RAMP;
          end
        end
        ST_RAMP: begin
          if (res.eq) begin
            state <= ST_IDLE;
          end else begin
            cur        <= cur_next;
            strobe     <= 1'b1;
            reg_addr   <= addr;
            reg_value  <= upper | {2'b00, cur_next};
            last_write <= (cur_next == to);
            if (cur_next == to) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `DVRS_ASSERT_NOW(a_last_has_strobe, last_write, strobe, "last_write without strobe")
  `DVRS_ASSERT_NOW(a_last_ends_ramp, strobe && last_write, !busy, "busy after last write")
  `DVRS_ASSERT_NOW(a_idx_in_field, busy, idx <= mask, "target index beyond field")
  `DVRS_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !strobe, "request not taken")

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps

module tb
  import dvrs_pkg::*;
();

  typedef struct {
    logic [2:0]  rail;
    logic [12:0] target;
    logic [7:0]  present;
    bit          drain;
  } ramp_req_t;

  typedef struct {
    logic [7:0] addr;
    logic [7:0] value;
    logic       last;
  } ramp_write_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  rail = '0;
  logic [12:0] target_mv = '0;
  logic [7:0]  present_reg = '0;
  logic        strobe;
  logic [7:0]  reg_addr;
  logic [7:0]  reg_value;
  logic        last_write;

  ramp_req_t   pending_reqs[$];
  ramp_write_t expected_writes[$];
  ramp_req_t   cur_req;
  bit          presenting = 0;
  int          burst_left = 1;
  int          gap_left = 0;
  int          errors = 0;

  dcdc_voltage_ramp_sequencer u_top (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .rail        (rail),
    .target_mv   (target_mv),
    .present_reg (present_reg),
    .strobe      (strobe),
    .reg_addr    (reg_addr),
    .reg_value   (reg_value),
    .last_write  (last_write)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got 0x%0h want 0x%0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Expected register writes for one ramp request.
  function automatic void predict_ramp(ramp_req_t r);
    logic [7:0]  fmask;
    int          base;
    int          step;
    int          v;
    int          to_idx;
    int          cur;
    logic [7:0]  upper;
    ramp_write_t w;
    if (r.rail == RAIL_COARSE) begin
      fmask = {2'b00, MASK_NARROW};
      base  = int'(BASE_COARSE);
      step  = int'(STEP_COARSE);
    end else if (r.rail == RAIL_MID) begin
      fmask = {2'b00, MASK_NARROW};
      base  = int'(BASE_MID);
      step  = int'(STEP_MID);
    end else begin
      fmask = {2'b00, MASK_WIDE};
      base  = int'(BASE_FINE);
      step  = int'(STEP_FINE);
    end
    to_idx = 0;
    v = base;
    while (to_idx < int'(fmask) && v < int'(r.target)) begin
      v += step;
      to_idx++;
    end
    cur = int'(r.present & fmask);
    upper = r.present & ~fmask;
    while (cur != to_idx) begin
      cur += (cur < to_idx) ? 1 : -1;
      w.addr  = ADDR_BASE + {5'b0, r.rail};
      w.value = upper | 8'(cur);
      w.last  = (cur == to_idx);
      expected_writes.push_back(w);
    end
  endfunction

  function automatic void add_req(logic [2:0] r, logic [12:0] t, logic [7:0] p, bit d);
    ramp_req_t q;
    q.rail    = r;
    q.target  = t;
    q.present = p;
    q.drain   = d;
    pending_reqs.push_back(q);
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        predict_ramp(cur_req);
        presenting = 0;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 16);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 140);
        end
      end
      if (!presenting) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_reqs.size() > 0 &&
                     !(pending_reqs[0].drain && expected_writes.size() != 0)) begin
          cur_req = pending_reqs.pop_front();
          presenting = 1;
        end
      end
      start       <= presenting;
      rail        <= cur_req.rail;
      target_mv   <= cur_req.target;
      present_reg <= cur_req.present;
    end
  end

  // monitor
  always @(posedge clk) begin : mon
    ramp_write_t w;
    if (!rst && strobe) begin
      if (expected_writes.size() == 0) begin
        report_mismatch("unexpected write addr", int'(reg_addr), 0);
      end else begin
        w = expected_writes.pop_front();
        if (reg_addr !== w.addr)
          report_mismatch("reg_addr", int'(reg_addr), int'(w.addr));
        if (reg_value !== w.value)
          report_mismatch("reg_value", int'(reg_value), int'(w.value));
        if (last_write !== w.last)
          report_mismatch("last_write", int'(last_write), int'(w.last));
      end
    end
  end

  initial begin : stim
    logic [2:0]  rr;
    logic [12:0] tt;
    // directed: full ramps, saturation, at/below base, equal index, upper bits
    add_req(3'd0, 13'd8191, 8'h00, 0);
    add_req(3'd0, 13'd0,    8'hff, 0);
    add_req(RAIL_COARSE, 13'd8191, 8'he0, 0);
    add_req(RAIL_COARSE, 13'd0,    8'h3f, 0);
    add_req(RAIL_MID,    13'd8191, 8'h00, 0);
    add_req(RAIL_MID,    13'd1000, 8'h1f, 0);
    add_req(RAIL_COARSE, 13'd1600, 8'h00, 0);
    add_req(3'd2, 13'd600,  8'h80, 0);
    add_req(3'd3, 13'd601,  8'h00, 0);
    add_req(3'd4, 13'd1860, 8'h55, 0);
    add_req(3'd6, 13'd1859, 8'h00, 0);
    add_req(3'd7, 13'd1840, 8'h3f, 0);
    add_req(RAIL_MID,    13'd1025, 8'ha3, 0);
    add_req(RAIL_COARSE, 13'd4700, 8'h1e, 0);
    add_req(RAIL_COARSE, 13'd4701, 8'h1f, 0);
    add_req(3'd0, 13'd599,  8'h2a, 0);
    add_req(3'd2, 13'd1000, 8'h14, 0);
    add_req(3'd7, 13'd4096, 8'h40, 0);
    add_req(RAIL_MID,    13'd2550, 8'hdf, 0);
    add_req(RAIL_MID,    13'd2600, 8'h20, 0);
    for (int i = 0; i < 400; i++) begin
      rr = 3'($urandom_range(0, 7));
      if ($urandom_range(0, 4) == 0) begin
        tt = 13'($urandom_range(0, 8191));
      end else if (rr == RAIL_COARSE) begin
        tt = 13'($urandom_range(1500, 4800));
      end else if (rr == RAIL_MID) begin
        tt = 13'($urandom_range(950, 2650));
      end else begin
        tt = 13'($urandom_range(560, 1900));
      end
      add_req(rr, tt, 8'($urandom_range(0, 255)), (i == 0) || (i == 200));
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (pending_reqs.size() != 0 || presenting || expected_writes.size() != 0)
      @(posedge clk);
    repeat (200) @(posedge clk);

    if (errors == 0 && expected_writes.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
